// File: src/mmix_pkg.sv
// Package for the hexacopter motor mixer: payload structs, register indexes,
// opcodes, controller states and the controller-to-datapath command word.
// No dependencies.
package mmix_pkg;

	localparam int MOTOR_COUNT = 6;
	localparam int AXIS_COUNT  = 4;
	localparam int COEF_W      = 16;
	localparam int ESC_W       = 16;
	localparam int CFG_W       = 64;
	localparam int CFG_IDX_W   = 3;
	localparam int MS_W        = 16;
	localparam int LIMITS_W    = 3 * ESC_W;

	localparam int MOTOR_IDX_W = $clog2(MOTOR_COUNT);
	localparam int AXIS_IDX_W  = $clog2(AXIS_COUNT);

	// Datapath widths: coefficient times command, the four-term sum, and the
	// scaled motor value with its armed-minimum offset and bias.
	localparam int MUL_A_W = 34;
	localparam int MUL_B_W = 17;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int ACC_W   = MUL_A_W;
	localparam int X_W     = 52;

	localparam logic [MS_W-1:0] HB_TIMEOUT_RESET = 16'd500;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_MIX_ROW_0  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIX_ROW_1  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MIX_ROW_2  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_MIX_ROW_3  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MIX_ROW_4  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MIX_ROW_5  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_ESC_LIMITS = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_HB_TIMEOUT = 3'd7;

	typedef enum logic [1:0] {
		OP_CMD  = 2'd0,
		OP_ARM  = 2'd1,
		OP_HB   = 2'd2,
		OP_TICK = 2'd3
	} opcode_t;

	typedef struct packed {
		opcode_t            opcode;
		logic signed [15:0] rate_x;
		logic signed [15:0] rate_y;
		logic signed [15:0] rate_z;
		logic signed [15:0] thrust;
		logic               arm_value;
	} in_item_t;

	typedef struct packed {
		logic [15:0] motor_0;
		logic [15:0] motor_1;
		logic [15:0] motor_2;
		logic [15:0] motor_3;
		logic [15:0] motor_4;
		logic [15:0] motor_5;
		logic        is_armed;
		logic        is_flying;
	} out_item_t;

	// One mixing row: index 0 x, 1 y, 2 z, 3 thrust.
	typedef logic [AXIS_COUNT-1:0][COEF_W-1:0]  mix_row_t;
	typedef mix_row_t [MOTOR_COUNT-1:0]         mix_rows_t;
	typedef logic [AXIS_COUNT-1:0][COEF_W-1:0]  cmd_vec_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_LAST,
		ST_SPAN,
		ST_STORE,
		ST_BIAS,
		ST_CLAMP,
		ST_DONE
	} ctrl_state_t;

	typedef struct packed {
		logic                   load_in;
		logic                   prod_en;
		logic                   mul_span;
		logic                   acc_add;
		logic                   acc_clr;
		logic                   x_wr;
		logic                   bias_en;
		logic                   clamp_wr;
		logic                   out_load;
		logic                   armed;
		logic                   flying;
		logic [MOTOR_IDX_W-1:0] motor;
		logic [AXIS_IDX_W-1:0]  axis;
	} dp_cmd_t;

endpackage

// File: src/mmix_ctrl.sv
// Controller of the motor mixer: arm and take-off flags, heartbeat age,
// and the sequencer that drives the datapath. Depends on mmix_pkg.
module mmix_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  mmix_pkg::opcode_t      opcode,
	input  logic                   arm_value,
	input  logic [15:0]            hb_timeout,
	output logic                   out_valid,
	input  logic                   out_stall,
	output mmix_pkg::dp_cmd_t      cmd
);
	import mmix_pkg::*;

	localparam logic [MOTOR_IDX_W-1:0] MOTOR_LAST = MOTOR_IDX_W'(MOTOR_COUNT - 1);
	localparam logic [AXIS_IDX_W-1:0]  AXIS_LAST  = AXIS_IDX_W'(AXIS_COUNT - 1);

	ctrl_state_t            state_q, state_d;
	logic [MOTOR_IDX_W-1:0] motor_q;
	logic [AXIS_IDX_W-1:0]  axis_q;
	logic                   armed_q, flying_q;
	logic [MS_W-1:0]        ms_q;
	logic                   out_valid_q;
	logic                   accept;

	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && opcode == OP_CMD)
					state_d = ST_MAC;
			end
			ST_MAC: begin
				if (axis_q == AXIS_LAST)
					state_d = ST_LAST;
			end
			ST_LAST:  state_d = ST_SPAN;
			ST_SPAN:  state_d = ST_STORE;
			ST_STORE: state_d = (motor_q == MOTOR_LAST) ? ST_BIAS : ST_MAC;
			ST_BIAS:  state_d = ST_CLAMP;
			ST_CLAMP: begin
				if (motor_q == MOTOR_LAST)
					state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || !out_stall)
					state_d = ST_IDLE;
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		cmd.motor  = motor_q;
		cmd.axis   = axis_q;
		cmd.armed  = armed_q;
		cmd.flying = flying_q;
		unique case (state_q)
			ST_IDLE:  cmd.load_in = accept && opcode == OP_CMD;
			ST_MAC: begin
				// The product of the previous axis is summed while the next one is formed.
				cmd.prod_en = 1'b1;
				cmd.acc_add = (axis_q != '0);
				cmd.acc_clr = (axis_q == AXIS_IDX_W'(1));
			end
			ST_LAST:  cmd.acc_add = 1'b1;
			ST_SPAN: begin
				cmd.prod_en  = 1'b1;
				cmd.mul_span = 1'b1;
			end
			ST_STORE: cmd.x_wr = 1'b1;
			ST_BIAS:  cmd.bias_en = 1'b1;
			ST_CLAMP: cmd.clamp_wr = 1'b1;
			ST_DONE:  cmd.out_load = !out_valid_q || !out_stall;
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			motor_q     <= '0;
			axis_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					motor_q <= '0;
					axis_q  <= '0;
				end
				ST_MAC:   axis_q <= axis_q + AXIS_IDX_W'(1);
				ST_STORE: motor_q <= (motor_q == MOTOR_LAST) ? '0 : motor_q + MOTOR_IDX_W'(1);
				ST_CLAMP: motor_q <= motor_q + MOTOR_IDX_W'(1);
				default:  ;
			endcase
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	// Flags and heartbeat age change only on accepted beats.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q  <= 1'b0;
			flying_q <= 1'b0;
			ms_q     <= '0;
		end else if (accept) begin
			unique case (opcode)
				OP_CMD: begin
					if (ms_q > hb_timeout) begin
						armed_q  <= 1'b0;
						flying_q <= 1'b0;
					end
				end
				OP_ARM: begin
					if (arm_value) begin
						if (armed_q)
							flying_q <= 1'b1;
						else
							armed_q <= 1'b1;
					end else begin
						armed_q  <= 1'b0;
						flying_q <= 1'b0;
					end
				end
				OP_HB:   ms_q <= '0;
				OP_TICK: begin
					if (ms_q != '1)
						ms_q <= ms_q + MS_W'(1);
				end
				default: ;
			endcase
		end
	end

	a_flying_needs_armed: assert property (@(posedge clk) disable iff (!arst_n)
		flying_q |-> armed_q)
		else $error("take-off flag set while disarmed");

	a_cmd_starts_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && opcode == OP_CMD) |=> (state_q == ST_MAC && motor_q == '0 && axis_q == '0))
		else $error("command did not start at motor 0, axis 0");

	a_ms_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		!(accept && opcode == OP_HB) |=> ms_q >= $past(ms_q))
		else $error("heartbeat age decreased without a heartbeat");

	a_no_result_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !out_stall))
		else $error("result register loaded while a stalled result waits");

endmodule

// File: src/mmix_dp.sv
// Datapath of the motor mixer: one shared signed multiplier, accumulator,
// per-motor value store, bias and clamp, and the result register. Depends on mmix_pkg.
module mmix_dp #(
	parameter int COEF_FRAC_BITS = 13
) (
	input  logic                        clk,
	input  mmix_pkg::dp_cmd_t           cmd,
	input  mmix_pkg::in_item_t          in_data,
	input  mmix_pkg::mix_rows_t         mix_rows,
	input  logic [mmix_pkg::LIMITS_W-1:0] esc_limits,
	output mmix_pkg::out_item_t         out_data
);
	import mmix_pkg::*;

	localparam int FRAC2 = 2 * COEF_FRAC_BITS;

	cmd_vec_t                   u_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [X_W-1:0]      x_q [MOTOR_COUNT];
	logic signed [X_W-1:0]      min_q;
	logic signed [X_W-1:0]      bias_q;
	logic [ESC_W-1:0]           res_q [MOTOR_COUNT];
	out_item_t                  out_q;

	logic [ESC_W-1:0]           amin, dval, emax;
	logic signed [MUL_B_W-1:0]  span;
	logic [COEF_W-1:0]          coef, ucmd;
	logic signed [MUL_A_W-1:0]  mul_a;
	logic signed [MUL_B_W-1:0]  mul_b;
	logic signed [PROD_W-1:0]   prod;
	logic signed [X_W-1:0]      base, x_new, x_biased, t, amin_x, emax_x;
	logic [ESC_W-1:0]           clamped;

	assign amin = esc_limits[ESC_W-1:0];
	assign dval = esc_limits[2*ESC_W-1:ESC_W];
	assign emax = esc_limits[3*ESC_W-1:2*ESC_W];
	assign span = $signed({1'b0, emax}) - $signed({1'b0, amin});

	assign coef  = mix_rows[cmd.motor][cmd.axis];
	assign ucmd  = u_q[cmd.axis];
	assign mul_a = cmd.mul_span ? acc_q
	                            : $signed({{(MUL_A_W-COEF_W){coef[COEF_W-1]}}, coef});
	assign mul_b = cmd.mul_span ? span
	                            : $signed({{(MUL_B_W-COEF_W){ucmd[COEF_W-1]}}, ucmd});
	assign prod  = mul_a * mul_b;

	assign amin_x = $signed({{(X_W-ESC_W){1'b0}}, amin});
	assign emax_x = $signed({{(X_W-ESC_W){1'b0}}, emax});
	assign base   = amin_x <<< FRAC2;
	assign x_new  = $signed({{(X_W-PROD_W){prod_q[PROD_W-1]}}, prod_q}) + base;

	// After the bias every motor value is at least the armed minimum, so an
	// arithmetic shift truncates toward zero.
	assign x_biased = x_q[cmd.motor] + bias_q;
	assign t        = x_biased >>> FRAC2;

	always_comb begin
		if (t > emax_x)
			clamped = emax;
		else if (t < amin_x)
			clamped = amin;
		else
			clamped = t[ESC_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in)
			u_q <= {in_data.thrust, in_data.rate_z, in_data.rate_y, in_data.rate_x};
		if (cmd.prod_en)
			prod_q <= prod;
		if (cmd.acc_add)
			acc_q <= (cmd.acc_clr ? '0 : acc_q) + prod_q[ACC_W-1:0];
		if (cmd.x_wr) begin
			x_q[cmd.motor] <= x_new;
			if (cmd.motor == '0 || x_new < min_q)
				min_q <= x_new;
		end
		if (cmd.bias_en)
			bias_q <= (min_q < base) ? base - min_q : '0;
		if (cmd.clamp_wr)
			res_q[cmd.motor] <= cmd.armed ? (cmd.flying ? clamped : amin) : dval;
		if (cmd.out_load) begin
			out_q.motor_0   <= res_q[0];
			out_q.motor_1   <= res_q[1];
			out_q.motor_2   <= res_q[2];
			out_q.motor_3   <= res_q[3];
			out_q.motor_4   <= res_q[4];
			out_q.motor_5   <= res_q[5];
			out_q.is_armed  <= cmd.armed;
			out_q.is_flying <= cmd.flying;
		end
	end

	assign out_data = out_q;

endmodule

// File: src/hexacopter_motor_mixer_core.sv
// Hexacopter motor mixer top level: configuration registers, controller and datapath.
// Depends on mmix_pkg, mmix_ctrl and mmix_dp.
//
// A command beat is accepted only while the controller is idle. One shared 34x17 signed
// multiplier forms the 24 coefficient products, one per cycle: for each motor it forms
// the four products while the sum is accumulated, finishes the sum, then forms one
// span product and stores the motor value. Then come the common bias, the clamping of
// one motor at a time, and the load of the output register. The input stalls during that
// work; arm, heartbeat and tick beats produce no result and leave the controller idle.
// A finished result waits in the output register,
// so the next beat is accepted while it is stalled; a following command holds off its
// own load until that result is taken.
// Configuration is written through cfg_we, cfg_idx and cfg_wdata at a clock edge; the user
// must write it only while the block is idle, as the block itself does not enforce this.
module hexacopter_motor_mixer_core #(
	parameter int COEF_FRAC_BITS = 13
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  mmix_pkg::in_item_t              in_data,
	output logic                            out_valid,
	input  logic                            out_stall,
	output mmix_pkg::out_item_t             out_data,
	input  logic                            cfg_we,
	input  logic [mmix_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [mmix_pkg::CFG_W-1:0]      cfg_wdata
);
	import mmix_pkg::*;

	mix_rows_t          mix_q;
	logic [LIMITS_W-1:0] limits_q;
	logic [MS_W-1:0]    timeout_q;
	dp_cmd_t            cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mix_q     <= '0;
			limits_q  <= '0;
			timeout_q <= HB_TIMEOUT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx) inside
				CFG_MIX_ROW_0, CFG_MIX_ROW_1, CFG_MIX_ROW_2,
				CFG_MIX_ROW_3, CFG_MIX_ROW_4, CFG_MIX_ROW_5:
					mix_q[cfg_idx] <= cfg_wdata;
				CFG_ESC_LIMITS: limits_q  <= cfg_wdata[LIMITS_W-1:0];
				CFG_HB_TIMEOUT: timeout_q <= cfg_wdata[MS_W-1:0];
				default: ;
			endcase
		end
	end

	mmix_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.opcode     (in_data.opcode),
		.arm_value  (in_data.arm_value),
		.hb_timeout (timeout_q),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.cmd        (cmd)
	);

	mmix_dp #(
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_dp (
		.clk        (clk),
		.cmd        (cmd),
		.in_data    (in_data),
		.mix_rows   (mix_q),
		.esc_limits (limits_q),
		.out_data   (out_data)
	);

endmodule
